// ===== sv/bounded_plane_distance_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Bounded plane distance unit: assertion macros
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PLANE_DISTANCE_UNIT_DEFINES_SVH
`define BOUNDED_PLANE_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication check.
`define BPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpd check failed");

// Next-cycle implication check.
`define BPD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpd check failed");

`endif

// ===== sv/bpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded plane distance package
// Beat types, basis and root-lane bundles, register indexes and a rounding helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bpd_pkg;

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_NORMAL_X = 3'd3;
    localparam logic [2:0] REG_NORMAL_Y = 3'd4;
    localparam logic [2:0] REG_NORMAL_Z = 3'd5;
    localparam logic [2:0] REG_HALF_W   = 3'd6;
    localparam logic [2:0] REG_HALF_H   = 3'd7;

    localparam logic signed [31:0] Q30_ONE      = 32'sd1073741824;
    localparam logic        [63:0] NEAR_ZERO_SQ = 64'd11529215047;
    localparam logic        [30:0] HALF_RESET   = 31'd65536;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] distance;
        logic        saturated;
    } t_out_beat;

    // Clamped normal and in-plane basis, scaled by 2^30: n and u are Q2.30, v is Q3.30.
    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] uz;
        logic signed [32:0] vx;
        logic signed [32:0] vy;
        logic signed [32:0] vz;
    } t_basis;

    // One lane of the square-root pipeline.
    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
        logic [31:0] ad;
        logic        sat;
    } t_root_lane;

    // Round a Q2.30-scaled product to Q16.16, half up.
    function automatic logic signed [36:0] rnd_q30(input logic signed [66:0] x);
        logic signed [66:0] y;
        y = x + 67'sd536870912;
        return y[66:30];
    endfunction

endpackage

`default_nettype wire

// ===== sv/bpd_basis.sv =====
// ----------------------------------------------------------------------------
// Bounded plane distance: basis sequencer
// Clamps the normal and derives u = normalize(n x axis), v = n x u with a
// bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_basis import bpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_nx,
    input  logic [31:0] i_ny,
    input  logic [31:0] i_nz,
    output logic        o_busy,
    output t_basis      o_basis
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LOAD = 4'd1;
    localparam logic [3:0] ST_SQ   = 4'd2;
    localparam logic [3:0] ST_SEL  = 4'd3;
    localparam logic [3:0] ST_ROOT = 4'd4;
    localparam logic [3:0] ST_DSET = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_VMUL = 4'd7;
    localparam logic [3:0] ST_VRND = 4'd8;

    function automatic logic signed [31:0] clamp_n(input logic [31:0] x);
        logic signed [31:0] s;
        s = $signed(x);
        if (s > Q30_ONE) return Q30_ONE;
        if (s < -Q30_ONE) return -Q30_ONE;
        return s;
    endfunction

    function automatic logic signed [32:0] rnd_diff(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] d;
        d = 65'(a) - 65'(b) + 65'sd536870912;
        return d[62:30];
    endfunction

    logic [3:0]  r_state;
    logic [4:0]  r_cnt;
    logic        r_pass;
    logic        r_br1;
    logic signed [31:0] r_nx, r_ny, r_nz, r_ux, r_uy, r_uz;
    logic signed [63:0] r_sqx, r_sqy, r_sqz;
    logic signed [63:0] r_p_yz, r_p_zy, r_p_zx, r_p_xz, r_p_xy, r_p_yx;
    logic signed [32:0] r_vx, r_vy, r_vz;
    logic [63:0] r_rad;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [30:0] r_drem;
    logic [30:0] r_dq;
    logic        r_aneg;

    logic signed [63:0] w_s1;
    logic [34:0] w_rem_sh, w_trial;
    logic        w_ge;
    logic signed [31:0] w_a;
    logic [31:0] w_amag;
    logic [61:0] w_num;
    logic [31:0] w_drem_sh;
    logic        w_dge;
    logic [31:0] w_dsub;
    logic [30:0] w_q;
    logic signed [31:0] w_u;

    assign w_s1      = r_sqx + r_sqz;
    assign w_rem_sh  = {r_rem[32:0], r_rad[63:62]};
    assign w_trial   = {1'b0, r_root, 2'b01};
    assign w_ge      = w_rem_sh >= w_trial;

    // Nonzero axis components: pass 0 covers x (first axis) or y (fallback).
    assign w_a = !r_pass ? (r_br1 ? -r_nz : r_nz) : (r_br1 ? r_nx : -r_ny);
    assign w_amag    = w_a[31] ? 32'(-w_a) : 32'(w_a);
    assign w_num     = {w_amag[31:0], 30'd0} + {31'd0, r_root[31:1]};
    assign w_drem_sh = {r_drem, r_dq[30]};
    assign w_dge     = w_drem_sh >= r_root;
    assign w_dsub    = w_drem_sh - r_root;
    assign w_q       = {r_dq[29:0], w_dge};
    assign w_u       = r_aneg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
        end else if (i_start) begin
            r_state <= ST_LOAD;
        end else begin
            case (r_state)
                ST_LOAD: r_state <= ST_SQ;
                ST_SQ:   r_state <= ST_SEL;
                ST_SEL: begin
                    r_state <= ST_ROOT;
                    r_cnt   <= '0;
                    r_pass  <= 1'b0;
                end
                ST_ROOT: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_state <= ST_DSET;
                end
                ST_DSET: begin
                    r_cnt   <= '0;
                    r_state <= (r_root == '0) ? ST_VMUL : ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        if (r_pass) begin
                            r_state <= ST_VMUL;
                        end else begin
                            r_pass  <= 1'b1;
                            r_state <= ST_DSET;
                        end
                    end
                end
                ST_VMUL: r_state <= ST_VRND;
                ST_VRND: r_state <= ST_IDLE;
                ST_IDLE: r_state <= ST_IDLE;
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                r_nx <= clamp_n(i_nx);
                r_ny <= clamp_n(i_ny);
                r_nz <= clamp_n(i_nz);
                r_ux <= '0;
                r_uy <= '0;
                r_uz <= '0;
            end
            ST_SQ: begin
                r_sqx <= r_nx * r_nx;
                r_sqy <= r_ny * r_ny;
                r_sqz <= r_nz * r_nz;
            end
            ST_SEL: begin
                r_br1  <= $unsigned(w_s1) >= NEAR_ZERO_SQ;
                r_rad  <= ($unsigned(w_s1) >= NEAR_ZERO_SQ) ? $unsigned(w_s1)
                                                            : $unsigned(r_sqy + r_sqz);
                r_rem  <= '0;
                r_root <= '0;
            end
            ST_ROOT: begin
                r_rad  <= {r_rad[61:0], 2'b00};
                r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root <= {r_root[30:0], w_ge};
            end
            ST_DSET: begin
                r_drem <= w_num[61:31];
                r_dq   <= w_num[30:0];
                r_aneg <= w_a[31];
            end
            ST_DIV: begin
                r_dq   <= w_q;
                r_drem <= w_dge ? w_dsub[30:0] : w_drem_sh[30:0];
                if (r_cnt == 5'd30) begin
                    if (r_pass)     r_uz <= w_u;
                    else if (r_br1) r_ux <= w_u;
                    else            r_uy <= w_u;
                end
            end
            ST_VMUL: begin
                r_p_yz <= r_ny * r_uz;
                r_p_zy <= r_nz * r_uy;
                r_p_zx <= r_nz * r_ux;
                r_p_xz <= r_nx * r_uz;
                r_p_xy <= r_nx * r_uy;
                r_p_yx <= r_ny * r_ux;
            end
            ST_VRND: begin
                r_vx <= rnd_diff(r_p_yz, r_p_zy);
                r_vy <= rnd_diff(r_p_zx, r_p_xz);
                r_vz <= rnd_diff(r_p_xy, r_p_yx);
            end
            default: begin
            end
        endcase
    end

    assign o_busy     = r_state != ST_IDLE;
    assign o_basis.nx = r_nx;
    assign o_basis.ny = r_ny;
    assign o_basis.nz = r_nz;
    assign o_basis.ux = r_ux;
    assign o_basis.uy = r_uy;
    assign o_basis.uz = r_uz;
    assign o_basis.vx = r_vx;
    assign o_basis.vy = r_vy;
    assign o_basis.vz = r_vz;

endmodule

`default_nettype wire

// ===== sv/bpd_proj.sv =====
// ----------------------------------------------------------------------------
// Bounded plane distance: projection stages
// Offset from centre, nine rounded products, sums, and excess over extents.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_proj import bpd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_in_beat           i_beat,
    input  logic signed [31:0] i_cx,
    input  logic signed [31:0] i_cy,
    input  logic signed [31:0] i_cz,
    input  logic [30:0]        i_hw,
    input  logic [30:0]        i_hh,
    input  t_basis             i_basis,
    output logic               o_valid,
    output logic [31:0]        o_dx,
    output logic [31:0]        o_dy,
    output logic [31:0]        o_ad,
    output logic               o_sat
);

    logic               r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic signed [32:0] r_rel [3];
    logic signed [36:0] r_td [3];
    logic signed [36:0] r_tx [3];
    logic signed [36:0] r_ty [3];
    logic signed [38:0] r_sd, r_sx, r_sy;
    logic [31:0]        r_dx, r_dy, r_ad;
    logic               r_sat;

    logic signed [32:0] w_n [3];
    logic signed [32:0] w_u [3];
    logic signed [32:0] w_v [3];
    logic signed [66:0] w_pd [3];
    logic signed [66:0] w_px [3];
    logic signed [66:0] w_py [3];
    logic [38:0]        w_ad, w_alx, w_aly, w_ex, w_ey;

    assign w_n[0] = 33'(i_basis.nx);
    assign w_n[1] = 33'(i_basis.ny);
    assign w_n[2] = 33'(i_basis.nz);
    assign w_u[0] = 33'(i_basis.ux);
    assign w_u[1] = 33'(i_basis.uy);
    assign w_u[2] = 33'(i_basis.uz);
    assign w_v[0] = i_basis.vx;
    assign w_v[1] = i_basis.vy;
    assign w_v[2] = i_basis.vz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pd[i] = r_rel[i] * w_n[i];
            w_px[i] = r_rel[i] * w_u[i];
            w_py[i] = r_rel[i] * w_v[i];
        end
    end

    assign w_ad  = r_sd[38] ? 39'(-r_sd) : 39'(r_sd);
    assign w_alx = r_sx[38] ? 39'(-r_sx) : 39'(r_sx);
    assign w_aly = r_sy[38] ? 39'(-r_sy) : 39'(r_sy);
    assign w_ex  = (w_alx > {8'd0, i_hw}) ? (w_alx - {8'd0, i_hw}) : '0;
    assign w_ey  = (w_aly > {8'd0, i_hh}) ? (w_aly - {8'd0, i_hh}) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rel[0] <= 33'(i_beat.point_x) - 33'(i_cx);
            r_rel[1] <= 33'(i_beat.point_y) - 33'(i_cy);
            r_rel[2] <= 33'(i_beat.point_z) - 33'(i_cz);
            for (int i = 0; i < 3; i++) begin
                r_td[i] <= rnd_q30(w_pd[i]);
                r_tx[i] <= rnd_q30(w_px[i]);
                r_ty[i] <= rnd_q30(w_py[i]);
            end
            r_sd  <= 39'(r_td[0]) + 39'(r_td[1]) + 39'(r_td[2]);
            r_sx  <= 39'(r_tx[0]) + 39'(r_tx[1]) + 39'(r_tx[2]);
            r_sy  <= 39'(r_ty[0]) + 39'(r_ty[1]) + 39'(r_ty[2]);
            r_dx  <= w_ex[31:0];
            r_dy  <= w_ey[31:0];
            r_ad  <= w_ad[31:0];
            r_sat <= (|w_ex[38:32]) | (|w_ey[38:32]) | (|w_ad[38:32]);
        end
    end

    assign o_valid = r_d_valid;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_ad    = r_ad;
    assign o_sat   = r_sat;

endmodule

`default_nettype wire

// ===== sv/bpd_root_step.sv =====
// ----------------------------------------------------------------------------
// Bounded plane distance: square-root step
// One registered digit of the restoring square root.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_root_step import bpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_root_lane i_lane,
    output logic       o_valid,
    output t_root_lane o_lane
);

    logic       r_valid;
    t_root_lane r_lane;
    logic [34:0] w_rem_sh, w_trial;
    logic        w_ge;

    assign w_rem_sh = {i_lane.rem[32:0], i_lane.rad[63:62]};
    assign w_trial  = {1'b0, i_lane.root, 2'b01};
    assign w_ge     = w_rem_sh >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane.rad  <= {i_lane.rad[61:0], 2'b00};
            r_lane.rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_lane.root <= {i_lane.root[30:0], w_ge};
            r_lane.ad   <= i_lane.ad;
            r_lane.sat  <= i_lane.sat;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

`default_nettype wire

// ===== sv/bpd_sqrt.sv =====
// ----------------------------------------------------------------------------
// Bounded plane distance: length stages
// Squares, 32 square-root steps, rounding, final add and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_sqrt import bpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_dx,
    input  logic [31:0] i_dy,
    input  logic [31:0] i_ad,
    input  logic        i_sat,
    output logic        o_valid,
    output t_out_beat   o_beat
);

    localparam int STEPS = 32;

    logic        r_e_valid, r_f_valid, r_h_valid;
    logic [63:0] r_sqx, r_sqy;
    logic [31:0] r_e_ad;
    logic        r_e_sat;
    t_root_lane  r_f_lane;
    t_out_beat   r_beat;

    logic       w_valid [STEPS+1];
    t_root_lane w_lane  [STEPS+1];
    logic [64:0] w_sum;
    logic [32:0] w_r;
    logic [33:0] w_total;
    logic        w_sat;

    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    assign w_valid[0] = r_f_valid;
    assign w_lane[0]  = r_f_lane;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        bpd_root_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[k]),
            .i_lane  (w_lane[k]),
            .o_valid (w_valid[k+1]),
            .o_lane  (w_lane[k+1])
        );
    end

    // Round to nearest: bump when the remainder passes the root.
    assign w_r     = {1'b0, w_lane[STEPS].root}
                   + {32'd0, (w_lane[STEPS].rem > {3'd0, w_lane[STEPS].root})};
    assign w_total = {1'b0, w_r} + {2'd0, w_lane[STEPS].ad};
    assign w_sat   = w_lane[STEPS].sat | (|w_total[33:32]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_h_valid <= 1'b0;
        end else if (i_en) begin
            r_e_valid <= i_valid;
            r_f_valid <= r_e_valid;
            r_h_valid <= w_valid[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx         <= i_dx * i_dx;
            r_sqy         <= i_dy * i_dy;
            r_e_ad        <= i_ad;
            r_e_sat       <= i_sat;
            r_f_lane.rad  <= w_sum[63:0];
            r_f_lane.rem  <= '0;
            r_f_lane.root <= '0;
            r_f_lane.ad   <= r_e_ad;
            r_f_lane.sat  <= r_e_sat | w_sum[64];
            r_beat.distance  <= w_sat ? '1 : w_total[31:0];
            r_beat.saturated <= w_sat;
        end
    end

    assign o_valid = r_h_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

// ===== sv/bounded_plane_distance_unit.sv =====
// ----------------------------------------------------------------------------
// Bounded plane distance unit
// Distance from a Q16.16 query point to a bounded rectangle in 3-D space.
// ----------------------------------------------------------------------------
//   channel   signals                                beat
//   ------    -------------------------------------  ---------------------------
//   input     i_in_valid / o_in_ready / i_in_beat    point_x, point_y, point_z
//   output    o_out_valid / i_out_ready / o_out_beat distance, saturated
//   config    psel penable pwrite paddr pwdata ...   8 registers, 4-byte stride
//
// One beat enters per cycle while o_in_ready is high; each result passes the
// projection stages, the squares, the 32-step square-root pipeline and the final add.
// After reset, and after any write to a normal register, the basis sequencer
// runs a bit-serial root and, for a nonzero root, two divides with o_in_ready low.
// A stall on the output freezes the whole pipeline in place; nothing is
// dropped or repeated, bubbles are kept.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_plane_distance_unit_defines.svh"

module bounded_plane_distance_unit import bpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_beat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_beat,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers (raw; the normal is clamped in the sequencer).
    logic signed [31:0] r_center_x, r_center_y, r_center_z;
    logic [31:0]        r_normal_x, r_normal_y, r_normal_z;
    logic [30:0]        r_half_w, r_half_h;

    logic        w_wr, w_start, w_basis_busy, w_en;
    logic [2:0]  w_idx;
    t_basis      w_basis;
    logic        w_p_valid, w_p_sat;
    logic [31:0] w_p_dx, w_p_dy, w_p_ad;

    assign pready  = 1'b1;
    assign w_idx   = paddr[4:2];
    assign w_wr    = psel & penable & pwrite;
    // Any normal write restarts the basis computation.
    assign w_start = w_wr && (w_idx inside {REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_normal_x <= '0;
            r_normal_y <= '0;
            r_normal_z <= Q30_ONE;
            r_half_w   <= HALF_RESET;
            r_half_h   <= HALF_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_CENTER_X: r_center_x <= pwdata;
                REG_CENTER_Y: r_center_y <= pwdata;
                REG_CENTER_Z: r_center_z <= pwdata;
                REG_NORMAL_X: r_normal_x <= pwdata;
                REG_NORMAL_Y: r_normal_y <= pwdata;
                REG_NORMAL_Z: r_normal_z <= pwdata;
                REG_HALF_W:   r_half_w   <= pwdata[30:0];
                REG_HALF_H:   r_half_h   <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CENTER_X: prdata = r_center_x;
            REG_CENTER_Y: prdata = r_center_y;
            REG_CENTER_Z: prdata = r_center_z;
            REG_NORMAL_X: prdata = r_normal_x;
            REG_NORMAL_Y: prdata = r_normal_y;
            REG_NORMAL_Z: prdata = r_normal_z;
            REG_HALF_W:   prdata = {1'b0, r_half_w};
            REG_HALF_H:   prdata = {1'b0, r_half_h};
            default:      prdata = '0;
        endcase
    end

    // Advance the pipeline whenever the output register is free or drained.
    assign w_en       = !o_out_valid || i_out_ready;
    // Hold input off while the basis is being rebuilt.
    assign o_in_ready = w_en && !w_basis_busy;

    bpd_basis u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_nx    (r_normal_x),
        .i_ny    (r_normal_y),
        .i_nz    (r_normal_z),
        .o_busy  (w_basis_busy),
        .o_basis (w_basis)
    );

    bpd_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid && !w_basis_busy),
        .i_beat  (i_in_beat),
        .i_cx    (r_center_x),
        .i_cy    (r_center_y),
        .i_cz    (r_center_z),
        .i_hw    (r_half_w),
        .i_hh    (r_half_h),
        .i_basis (w_basis),
        .o_valid (w_p_valid),
        .o_dx    (w_p_dx),
        .o_dy    (w_p_dy),
        .o_ad    (w_p_ad),
        .o_sat   (w_p_sat)
    );

    bpd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_p_valid),
        .i_dx    (w_p_dx),
        .i_dy    (w_p_dy),
        .i_ad    (w_p_ad),
        .i_sat   (w_p_sat),
        .o_valid (o_out_valid),
        .o_beat  (o_out_beat)
    );

    // A clamped result always reads as all ones.
    `BPD_ASSERT_IMP(a_sat_all_ones, o_out_valid && o_out_beat.saturated,
                    o_out_beat.distance == 32'hFFFF_FFFF)
    // A normal write must take the sequencer out of idle.
    `BPD_ASSERT_NXT(a_start_busy, w_start, w_basis_busy)
    // No beat may enter while the basis is stale.
    `BPD_ASSERT_IMP(a_busy_blocks, w_basis_busy, !o_in_ready)

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Bounded plane distance unit testbench
// Writes rectangle settings over APB, streams query points with random gaps,
// stalls the result side at random, and checks every result beat against a
// fixed-point distance predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

import bpd_pkg::*;

class distance_scoreboard;
    logic [31:0] regs [8];
    t_out_beat   expected_dist [$];
    int          errors;

    function new();
        regs[REG_CENTER_X] = 32'd0;
        regs[REG_CENTER_Y] = 32'd0;
        regs[REG_CENTER_Z] = 32'd0;
        regs[REG_NORMAL_X] = 32'd0;
        regs[REG_NORMAL_Y] = 32'd0;
        regs[REG_NORMAL_Z] = 32'(Q30_ONE);
        regs[REG_HALF_W]   = 32'(HALF_RESET);
        regs[REG_HALF_H]   = 32'(HALF_RESET);
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        if (idx == REG_HALF_W || idx == REG_HALF_H)
            regs[idx] = {1'b0, val[30:0]};
        else
            regs[idx] = val;
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    static function longint clamp_q30(logic [31:0] raw);
        longint x;
        x = longint'(signed'(raw));
        if (x > longint'(Q30_ONE)) return longint'(Q30_ONE);
        if (x < -longint'(Q30_ONE)) return -longint'(Q30_ONE);
        return x;
    endfunction

    // Round a Q30-scaled product half up; arithmetic shift floors.
    static function longint round_half_up(longint x);
        return (x + 64'sd536870912) >>> 30;
    endfunction

    static function logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    static function longint unit_part(longint a, logic [63:0] len);
        logic [63:0] mag;
        longint q;
        mag = 64'(a < 0 ? -a : a) << 30;
        q = longint'((mag + (len >> 1)) / len);
        return a < 0 ? -q : q;
    endfunction

    function t_out_beat predict_distance(t_in_beat p);
        longint rel [3], n [3], a [3], u [3], v [3];
        longint d, lx, ly, s1, s2;
        logic [63:0] len, hw, hh, alx, aly, dx, dy, ad, sq, r, total;
        t_out_beat res;
        rel[0] = longint'(p.point_x) - longint'(signed'(regs[REG_CENTER_X]));
        rel[1] = longint'(p.point_y) - longint'(signed'(regs[REG_CENTER_Y]));
        rel[2] = longint'(p.point_z) - longint'(signed'(regs[REG_CENTER_Z]));
        n[0] = clamp_q30(regs[REG_NORMAL_X]);
        n[1] = clamp_q30(regs[REG_NORMAL_Y]);
        n[2] = clamp_q30(regs[REG_NORMAL_Z]);
        hw = {33'd0, regs[REG_HALF_W][30:0]};
        hh = {33'd0, regs[REG_HALF_H][30:0]};
        d = 0;
        for (int i = 0; i < 3; i++) d += round_half_up(rel[i] * n[i]);
        // Fall back to the x axis when n x y-axis is too short.
        len = 0;
        s1 = n[0] * n[0] + n[2] * n[2];
        if (s1 >= longint'(NEAR_ZERO_SQ)) begin
            a[0] = -n[2]; a[1] = 0; a[2] = n[0];
            len = int_sqrt(64'(s1));
        end else begin
            s2 = n[1] * n[1] + n[2] * n[2];
            a[0] = 0; a[1] = n[2]; a[2] = -n[1];
            if (s2 > 0) len = int_sqrt(64'(s2));
        end
        for (int i = 0; i < 3; i++) u[i] = (len != 0) ? unit_part(a[i], len) : 0;
        v[0] = round_half_up(n[1] * u[2] - n[2] * u[1]);
        v[1] = round_half_up(n[2] * u[0] - n[0] * u[2]);
        v[2] = round_half_up(n[0] * u[1] - n[1] * u[0]);
        lx = 0;
        ly = 0;
        for (int i = 0; i < 3; i++) begin
            lx += round_half_up(rel[i] * u[i]);
            ly += round_half_up(rel[i] * v[i]);
        end
        alx = 64'(lx < 0 ? -lx : lx);
        aly = 64'(ly < 0 ? -ly : ly);
        dx = alx > hw ? alx - hw : 0;
        dy = aly > hh ? aly - hh : 0;
        ad = 64'(d < 0 ? -d : d);
        res.distance  = 32'hFFFF_FFFF;
        res.saturated = 1'b1;
        if (dx > 64'hFFFF_FFFF || dy > 64'hFFFF_FFFF || ad > 64'hFFFF_FFFF) return res;
        sq = dx * dx + dy * dy;
        if (sq < dx * dx) return res;
        r = int_sqrt(sq);
        if (sq - r * r > r) r++;
        total = r + ad;
        if (total > 64'hFFFF_FFFF) return res;
        res.distance  = total[31:0];
        res.saturated = 1'b0;
        return res;
    endfunction

    function void note_point(t_in_beat p);
        expected_dist.push_back(predict_distance(p));
    endfunction

    task check_result(t_out_beat got);
        t_out_beat want;
        if (expected_dist.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        want = expected_dist.pop_front();
        if (got.distance !== want.distance)
            report($sformatf("distance %h, want %h", got.distance, want.distance));
        if (got.saturated !== want.saturated)
            report($sformatf("saturated %b, want %b", got.saturated, want.saturated));
    endtask
endclass

module testbench;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_beat    i_in_beat = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_beat   o_out_beat;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    distance_scoreboard sb = new();
    bit  no_gaps = 1'b0;    // when set, both sides run without idling
    int  stall_left = 0;

    bounded_plane_distance_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_beat(i_in_beat),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_beat(o_out_beat),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 0;
    end

    // Result side: check each accepted beat, then hold ready low for a
    // freshly drawn number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_beat);
            stall_left = no_gaps ? 0 : $urandom_range(0, 10);
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Write one register: setup cycle, then access cycle.
    task write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Drop valid, drain all outstanding results and let the pipeline settle
    // before touching any register.
    task drain_pipe();
        i_in_valid <= 1'b0;
        while (sb.expected_dist.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task set_rect(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                  logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                  logic [31:0] hw, logic [31:0] hh);
        drain_pipe();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_HALF_W, hw);
        write_reg(REG_HALF_H, hh);
    endtask

    // Present one point after a random gap; return at the accepting edge.
    // A zero gap keeps valid high straight into the next beat.
    task send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        t_in_beat p;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= p;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_point(p);
    endtask

    // Mostly points near the centre so results stay in range; some anywhere.
    function logic [31:0] near_coord(logic [31:0] c);
        if ($urandom_range(0, 3) == 0) return $urandom;
        return c + 32'(signed'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
    endfunction

    function logic [31:0] rand_normal();
        case ($urandom_range(0, 5))
            0:       return $urandom;                    // exercise clamping
            1:       return 32'(Q30_ONE);
            2:       return -32'(Q30_ONE);
            3:       return 32'd0;
            4:       return $urandom_range(0, 32'h0000_4000) - 32'h2000; // tiny
            default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    initial begin
        logic [31:0] cx, cy, cz, hw, hh;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: unit z normal, half-extents of one unit.
        no_gaps = 1'b1;
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
        send_point(32'h0003_0000, 32'h0004_0000, 32'hFFFE_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        no_gaps = 1'b0;

        // Normal along y: near-zero test picks the x-axis fallback.
        set_rect(0, 0, 0, 0, 32'(Q30_ONE), 0, 32'h0002_0000, 0);
        send_point(32'h0005_0000, 32'h0001_0000, 32'h0003_0000);
        send_point(32'hFFFB_0000, 32'hFFFF_0000, 32'h0000_0001);
        // Zero normal: degenerate basis, distance zero.
        set_rect(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_point(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
        // Out-of-range normal components get clamped; widest half-extents.
        set_rect(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        // Negative x normal, then a normal near y (fallback on short cross product).
        set_rect(0, 0, 0, -32'(Q30_ONE), 0, 0, 32'h0000_0001, 32'h0001_0000);
        send_point(32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        set_rect(0, 0, 0, 32'h0000_1000, 32'h2000_0000, 32'h0000_0800, 0, 0);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0002_0000);

        // Random phases with fresh settings each.
        for (int ph = 0; ph < 10; ph++) begin
            cx = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
            cy = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
            cz = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
            hw = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
            hh = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
            set_rect(cx, cy, cz, rand_normal(), rand_normal(), rand_normal(), hw, hh);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 40; k++)
                send_point(near_coord(cx), near_coord(cy), near_coord(cz));
        end
        i_in_valid <= 1'b0;
        no_gaps = 1'b0;

        while (sb.expected_dist.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end
endmodule

`default_nettype wire
